// ===== src/point_segment_projection_core_macros.svh =====
// Assertion macros for the point-segment projection core checker.
// Used by psp_checker.sv; no other dependencies.
`ifndef POINT_SEGMENT_PROJECTION_CORE_MACROS_SVH
`define POINT_SEGMENT_PROJECTION_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define PSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked in and out of reset
`define PSP_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/psp_pkg.sv =====
// Shared types and constants of the point-segment projection core.
// No dependencies.
package psp_pkg;

  localparam int unsigned CoordW = 16;  // Q12.4 coordinate
  localparam int unsigned DiffW  = 17;  // coordinate difference
  localparam int unsigned SqW    = 33;  // squared lengths, e in interior case
  localparam int unsigned QSteps = 33;  // quotient bits of e*e/f

  typedef enum logic [1:0] {
    REG_BEFORE   = 2'd0,
    REG_INTERIOR = 2'd1,
    REG_PAST     = 2'd2,
    REG_DEGEN    = 2'd3
  } psp_region_e;

  // side data that rides along the divider chain
  typedef struct packed {
    psp_region_e              region;
    logic [CoordW-1:0]        sx;
    logic [CoordW-1:0]        sy;
    logic signed [DiffW-1:0]  dx;
    logic signed [DiffW-1:0]  dy;
    logic [SqW-1:0]           sq_dist;  // |v|^2, or |point-end|^2 past the end
  } psp_geo_t;

endpackage

// ===== src/psp_if.sv =====
// Valid/ready channel interfaces of the point-segment projection core.
// Depends on nothing but the payload widths below.
interface psp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] start_x;
  logic [15:0] start_y;
  logic [15:0] end_x;
  logic [15:0] end_y;
  logic [15:0] point_x;
  logic [15:0] point_y;

  modport source (output valid, start_x, start_y, end_x, end_y, point_x, point_y,
                  input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, point_x, point_y,
                  output ready);
endinterface

interface psp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] closest_x;
  logic [15:0] closest_y;
  logic [32:0] squared_distance;
  logic [1:0]  region;

  modport source (output valid, closest_x, closest_y, squared_distance, region,
                  input ready);
  modport sink   (input valid, closest_x, closest_y, squared_distance, region,
                  output ready);
endinterface

// ===== src/point_segment_projection_core.sv =====
// Top level of the point-segment projection core.
// Depends on psp_pkg, psp_if, psp_front, psp_cell and psp_back.
//
// Each input beat on in_i carries a segment (start, end) and a query point,
// all signed Q12.4. Each beat produces exactly one output beat on out_o:
// the closest point on the segment, its squared distance (Q.8) and a region
// code (before start, interior, past end, degenerate segment).
// Results leave in the order the beats arrived.
//
// Throughput: one beat per cycle while out_o is not stalled. The pipeline is
// the divider chain of one cell per quotient bit
// plus four front stages and two back stages.
// The pipeline advances as one: while out_o holds a beat the receiver has not
// taken, every stage holds and in_i.ready is low; otherwise in_i.ready is high
// and bubbles move along with the data.
// Reset (rst_ni low, asynchronous) clears all valid bits; the block accepts
// beats as soon as reset is released.
module point_segment_projection_core #(
  parameter int unsigned T_FRAC_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  psp_in_if.sink     in_i,
  psp_out_if.source  out_o
);

  localparam int unsigned W     = psp_pkg::SqW;
  localparam int unsigned NCELL = (T_FRAC_BITS > psp_pkg::QSteps) ? T_FRAC_BITS
                                                                   : psp_pkg::QSteps;

  logic en;

  logic                  c_vld [NCELL+1];
  psp_pkg::psp_geo_t     c_geo [NCELL+1];
  logic [W-1:0]          c_f   [NCELL+1];
  logic [W-1:0]          c_rt  [NCELL+1];
  logic [T_FRAC_BITS-1:0] c_qt [NCELL+1];
  logic [W-1:0]          c_rq  [NCELL+1];
  logic [W-1:0]          c_nq  [NCELL+1];
  logic [W-1:0]          c_qq  [NCELL+1];

  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  psp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (in_i.valid),
    .sx_i    (in_i.start_x),
    .sy_i    (in_i.start_y),
    .ex_i    (in_i.end_x),
    .ey_i    (in_i.end_y),
    .px_i    (in_i.point_x),
    .py_i    (in_i.point_y),
    .vld_o   (c_vld[0]),
    .geo_o   (c_geo[0]),
    .f_o     (c_f[0]),
    .e_o     (c_rt[0]),
    .e2_hi_o (c_rq[0]),
    .e2_lo_o (c_nq[0])
  );

  assign c_qt[0] = '0;
  assign c_qq[0] = '0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    psp_cell #(
      .TBITS (T_FRAC_BITS),
      .DO_T  (i >= (NCELL - T_FRAC_BITS)),
      .DO_Q  (i >= (NCELL - psp_pkg::QSteps))
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (c_vld[i]),
      .geo_i  (c_geo[i]),
      .f_i    (c_f[i]),
      .rt_i   (c_rt[i]),
      .qt_i   (c_qt[i]),
      .rq_i   (c_rq[i]),
      .nq_i   (c_nq[i]),
      .qq_i   (c_qq[i]),
      .vld_o  (c_vld[i+1]),
      .geo_o  (c_geo[i+1]),
      .f_o    (c_f[i+1]),
      .rt_o   (c_rt[i+1]),
      .qt_o   (c_qt[i+1]),
      .rq_o   (c_rq[i+1]),
      .nq_o   (c_nq[i+1]),
      .qq_o   (c_qq[i+1])
    );
  end

  psp_back #(
    .TBITS (T_FRAC_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (c_vld[NCELL]),
    .geo_i    (c_geo[NCELL]),
    .t_i      (c_qt[NCELL]),
    .q_i      (c_qq[NCELL]),
    .vld_o    (out_o.valid),
    .cx_o     (out_o.closest_x),
    .cy_o     (out_o.closest_y),
    .dist_o   (out_o.squared_distance),
    .region_o (out_o.region)
  );

endmodule

// ===== src/psp_front.sv =====
// Front end: differences, dot products, case split and e*e.
// Depends on psp_pkg.
module psp_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  logic [15:0]               sx_i,
  input  logic [15:0]               sy_i,
  input  logic [15:0]               ex_i,
  input  logic [15:0]               ey_i,
  input  logic [15:0]               px_i,
  input  logic [15:0]               py_i,
  output logic                      vld_o,
  output psp_pkg::psp_geo_t         geo_o,
  output logic [psp_pkg::SqW-1:0]   f_o,
  output logic [psp_pkg::SqW-1:0]   e_o,
  output logic [psp_pkg::SqW-1:0]   e2_hi_o,
  output logic [psp_pkg::SqW-1:0]   e2_lo_o
);

  // stage 1: input beat
  logic        v1_q;
  logic [15:0] sx_q, sy_q, ex_q, ey_q, px_q, py_q;

  // stage 2: dot products
  logic signed [16:0] dx, dy, vx, vy, wx, wy;
  logic signed [33:0] pvx, pvy, pdx, pdy, pvv1, pvv2, pww1, pww2;
  logic               v2_q;
  logic signed [34:0] e_q;
  logic [32:0]        f2_q, vv_q, ww_q;
  logic [15:0]        sx2_q, sy2_q;
  logic signed [16:0] dx2_q, dy2_q;

  // stage 3: case split and partial products of e*e
  logic               f_zero, e_le0, e_ge;
  logic [32:0]        e33;
  logic               v3_q;
  psp_pkg::psp_geo_t  geo3_d, geo3_q;
  logic [32:0]        f3_q, e3_q;
  logic [33:0]        ph_q;
  logic [32:0]        pm_q;
  logic [31:0]        pl_q;

  // stage 4
  logic [65:0]        e2;

  always_comb begin
    dx   = $signed({ex_q[15], ex_q}) - $signed({sx_q[15], sx_q});
    dy   = $signed({ey_q[15], ey_q}) - $signed({sy_q[15], sy_q});
    vx   = $signed({px_q[15], px_q}) - $signed({sx_q[15], sx_q});
    vy   = $signed({py_q[15], py_q}) - $signed({sy_q[15], sy_q});
    wx   = $signed({px_q[15], px_q}) - $signed({ex_q[15], ex_q});
    wy   = $signed({py_q[15], py_q}) - $signed({ey_q[15], ey_q});
    pvx  = vx * dx;
    pvy  = vy * dy;
    pdx  = dx * dx;
    pdy  = dy * dy;
    pvv1 = vx * vx;
    pvv2 = vy * vy;
    pww1 = wx * wx;
    pww2 = wy * wy;
  end

  always_comb begin
    f_zero = (f2_q == '0);
    e_le0  = e_q[34] || (e_q == '0);
    e_ge   = !e_q[34] && (e_q[33:0] >= {1'b0, f2_q});
    e33    = e_q[32:0];
    geo3_d.sx      = sx2_q;
    geo3_d.sy      = sy2_q;
    geo3_d.dx      = dx2_q;
    geo3_d.dy      = dy2_q;
    geo3_d.sq_dist = vv_q;
    if (f_zero) begin
      geo3_d.region = psp_pkg::REG_DEGEN;
    end else if (e_le0) begin
      geo3_d.region = psp_pkg::REG_BEFORE;
    end else if (e_ge) begin
      geo3_d.region  = psp_pkg::REG_PAST;
      geo3_d.sq_dist = ww_q;
    end else begin
      geo3_d.region = psp_pkg::REG_INTERIOR;
    end
  end

  // e*e = eh^2 * 2^32 + eh*el * 2^17 + el^2
  assign e2 = 66'({ph_q, 32'd0}) + 66'({pm_q, 17'd0}) + 66'(pl_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      vld_o <= 1'b0;
    end else if (en_i) begin
      v1_q  <= vld_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      vld_o <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q    <= sx_i;
      sy_q    <= sy_i;
      ex_q    <= ex_i;
      ey_q    <= ey_i;
      px_q    <= px_i;
      py_q    <= py_i;

      e_q     <= 35'(pvx) + 35'(pvy);
      f2_q    <= 33'(pdx) + 33'(pdy);
      vv_q    <= 33'(pvv1) + 33'(pvv2);
      ww_q    <= 33'(pww1) + 33'(pww2);
      sx2_q   <= sx_q;
      sy2_q   <= sy_q;
      dx2_q   <= dx;
      dy2_q   <= dy;

      geo3_q  <= geo3_d;
      f3_q    <= f2_q;
      e3_q    <= e33;
      ph_q    <= e33[32:16] * e33[32:16];
      pm_q    <= e33[32:16] * e33[15:0];
      pl_q    <= e33[15:0] * e33[15:0];

      geo_o   <= geo3_q;
      f_o     <= f3_q;
      e_o     <= e3_q;
      e2_hi_o <= e2[65:33];
      e2_lo_o <= e2[32:0];
    end
  end

endmodule

// ===== src/psp_cell.sv =====
// One divider cell: one restoring step of e*2^T/f and of e*e/f.
// Depends on psp_pkg.
module psp_cell #(
  parameter int unsigned TBITS = 16,
  parameter bit          DO_T  = 1'b1,
  parameter bit          DO_Q  = 1'b1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  psp_pkg::psp_geo_t         geo_i,
  input  logic [psp_pkg::SqW-1:0]   f_i,
  input  logic [psp_pkg::SqW-1:0]   rt_i,
  input  logic [TBITS-1:0]          qt_i,
  input  logic [psp_pkg::SqW-1:0]   rq_i,
  input  logic [psp_pkg::SqW-1:0]   nq_i,
  input  logic [psp_pkg::SqW-1:0]   qq_i,
  output logic                      vld_o,
  output psp_pkg::psp_geo_t         geo_o,
  output logic [psp_pkg::SqW-1:0]   f_o,
  output logic [psp_pkg::SqW-1:0]   rt_o,
  output logic [TBITS-1:0]          qt_o,
  output logic [psp_pkg::SqW-1:0]   rq_o,
  output logic [psp_pkg::SqW-1:0]   nq_o,
  output logic [psp_pkg::SqW-1:0]   qq_o
);

  localparam int unsigned W = psp_pkg::SqW;

  logic [W:0]   t_try, q_try, t_sub, q_sub;
  logic         t_ge, q_ge;
  logic [W-1:0] rt_d, rq_d, nq_d, qq_d;
  logic [TBITS-1:0] qt_d;

  always_comb begin
    t_try = {rt_i, 1'b0};
    q_try = {rq_i, nq_i[W-1]};
    t_sub = t_try - {1'b0, f_i};
    q_sub = q_try - {1'b0, f_i};
    t_ge  = (t_try >= {1'b0, f_i});
    q_ge  = (q_try >= {1'b0, f_i});
    rt_d  = rt_i;
    qt_d  = qt_i;
    rq_d  = rq_i;
    nq_d  = nq_i;
    qq_d  = qq_i;
    if (DO_T) begin
      rt_d = t_ge ? t_sub[W-1:0] : t_try[W-1:0];
      qt_d = {qt_i[TBITS-2:0], t_ge};
    end
    if (DO_Q) begin
      rq_d = q_ge ? q_sub[W-1:0] : q_try[W-1:0];
      nq_d = {nq_i[W-2:0], 1'b0};
      qq_d = {qq_i[W-2:0], q_ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geo_o <= geo_i;
      f_o   <= f_i;
      rt_o  <= rt_d;
      qt_o  <= qt_d;
      rq_o  <= rq_d;
      nq_o  <= nq_d;
      qq_o  <= qq_d;
    end
  end

endmodule

// ===== src/psp_back.sv =====
// Back end: scales t by the segment direction and forms the result beat.
// Depends on psp_pkg.
module psp_back #(
  parameter int unsigned TBITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      vld_i,
  input  psp_pkg::psp_geo_t         geo_i,
  input  logic [TBITS-1:0]          t_i,
  input  logic [psp_pkg::SqW-1:0]   q_i,
  output logic                      vld_o,
  output logic [15:0]               cx_o,
  output logic [15:0]               cy_o,
  output logic [32:0]               dist_o,
  output logic [1:0]                region_o
);

  localparam int unsigned PW = TBITS + 16;

  logic [15:0]        mag_x, mag_y;
  logic               v1_q;
  psp_pkg::psp_geo_t  geo_q;
  logic [psp_pkg::SqW-1:0] q_q;
  logic [PW-1:0]      px_q, py_q;

  logic [PW:0]        rnd_x, rnd_y;
  logic signed [17:0] ox, oy;
  logic [15:0]        cx_d, cy_d;
  logic [32:0]        dist_d;

  always_comb begin
    mag_x = geo_i.dx[16] ? 16'(-geo_i.dx) : geo_i.dx[15:0];
    mag_y = geo_i.dy[16] ? 16'(-geo_i.dy) : geo_i.dy[15:0];
  end

  // floor(t*d / 2^T): truncate for d >= 0, round the magnitude up for d < 0
  always_comb begin
    rnd_x = {1'b0, px_q} + {{(PW - TBITS + 1){1'b0}}, {TBITS{1'b1}}};
    rnd_y = {1'b0, py_q} + {{(PW - TBITS + 1){1'b0}}, {TBITS{1'b1}}};
    ox = geo_q.dx[16] ? -$signed(18'(rnd_x[PW:TBITS])) : $signed(18'(px_q[PW-1:TBITS]));
    oy = geo_q.dy[16] ? -$signed(18'(rnd_y[PW:TBITS])) : $signed(18'(py_q[PW-1:TBITS]));
    cx_d   = geo_q.sx;
    cy_d   = geo_q.sy;
    dist_d = geo_q.sq_dist;
    case (geo_q.region)
      psp_pkg::REG_INTERIOR: begin
        cx_d   = geo_q.sx + ox[15:0];
        cy_d   = geo_q.sy + oy[15:0];
        dist_d = (geo_q.sq_dist >= q_q) ? geo_q.sq_dist - q_q : '0;
      end
      psp_pkg::REG_PAST: begin
        cx_d = geo_q.sx + geo_q.dx[15:0];
        cy_d = geo_q.sy + geo_q.dy[15:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      vld_o <= 1'b0;
    end else if (en_i) begin
      v1_q  <= vld_i;
      vld_o <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      geo_q    <= geo_i;
      q_q      <= q_i;
      px_q     <= t_i * mag_x;
      py_q     <= t_i * mag_y;
      cx_o     <= cx_d;
      cy_o     <= cy_d;
      dist_o   <= dist_d;
      region_o <= geo_q.region;
    end
  end

endmodule

// ===== src/psp_checker.sv =====
// Port-level checks of the point-segment projection core, bound to the top.
// Depends on point_segment_projection_core_macros.svh.
`include "point_segment_projection_core_macros.svh"

module psp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] closest_x_i,
  input logic [15:0] closest_y_i,
  input logic [32:0] dist_i,
  input logic [1:0]  region_i
);

  // reset empties the pipe
  `PSP_ASSERT_ALWAYS(a_reset_clears, clk_i, !rst_ni, !out_valid_i, "output valid after reset")

  // input side stalls only while an output beat is stuck
  `PSP_ASSERT_NOW(a_ready_rule, clk_i, rst_ni, 1'b1, in_ready_i == (!out_valid_i || out_ready_i), "ready does not follow output stall")

  // stalled output beat stays
  `PSP_ASSERT_NEXT(a_valid_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "output valid dropped while stalled")

  `PSP_ASSERT_NEXT(a_data_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(closest_x_i) && $stable(closest_y_i) && $stable(dist_i) && $stable(region_i), "output beat changed while stalled")

endmodule

bind point_segment_projection_core psp_checker u_psp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .closest_x_i (out_o.closest_x),
  .closest_y_i (out_o.closest_y),
  .dist_i      (out_o.squared_distance),
  .region_i    (out_o.region)
);

// ===== verif/tb_point_segment_projection_core.sv =====
// Self-checking testbench for point_segment_projection_core.
// Depends on psp_pkg and psp_if; drives segment/point beats and checks the
// closest point, squared distance and region against an in-bench projection.
module tb_point_segment_projection_core;

  localparam int unsigned TFrac     = 16;
  localparam int unsigned Latency   = 6 + ((33 > TFrac) ? 33 : TFrac);
  localparam longint      CycleLimit = 400000;

  typedef struct {
    logic [15:0] cx;
    logic [15:0] cy;
    logic [32:0] sq_dist;
    psp_pkg::psp_region_e region;
  } projection_t;

  logic clk;
  logic rst_n;

  psp_in_if  in_if ();
  psp_out_if out_if ();

  point_segment_projection_core #(.T_FRAC_BITS(TFrac)) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  projection_t pending_q[$];
  int          fail_count;
  longint      cycle_count;
  int          send_idle_pct;
  int          stall_pct;
  int          hold_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.start_x = '0;
    in_if.start_y = '0;
    in_if.end_x   = '0;
    in_if.end_y   = '0;
    in_if.point_x = '0;
    in_if.point_y = '0;
    out_if.ready  = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  // closest point on segment, all math exact in 64/128 bits
  function automatic projection_t project(logic signed [15:0] sx, logic signed [15:0] sy,
                                          logic signed [15:0] ex, logic signed [15:0] ey,
                                          logic signed [15:0] px, logic signed [15:0] py);
    longint dx, dy, vx, vy, wx, wy, e, f, vv, t, q;
    logic [127:0] ee;
    projection_t r;
    dx = longint'(ex) - longint'(sx);
    dy = longint'(ey) - longint'(sy);
    vx = longint'(px) - longint'(sx);
    vy = longint'(py) - longint'(sy);
    e  = vx * dx + vy * dy;
    f  = dx * dx + dy * dy;
    vv = vx * vx + vy * vy;
    if (f == 0 || e <= 0) begin
      r.cx      = sx;
      r.cy      = sy;
      r.sq_dist = vv[32:0];
      r.region  = (f == 0) ? psp_pkg::REG_DEGEN : psp_pkg::REG_BEFORE;
    end else if (e >= f) begin
      wx        = longint'(px) - longint'(ex);
      wy        = longint'(py) - longint'(ey);
      r.cx      = ex;
      r.cy      = ey;
      r.sq_dist = 33'(wx * wx + wy * wy);
      r.region  = psp_pkg::REG_PAST;
    end else begin
      t  = (e <<< TFrac) / f;
      ee = 128'(e) * 128'(e);
      q  = longint'(ee / 128'(f));
      r.cx      = 16'(longint'(sx) + ((t * dx) >>> TFrac));
      r.cy      = 16'(longint'(sy) + ((t * dy) >>> TFrac));
      r.sq_dist = (vv >= q) ? 33'(vv - q) : '0;
      r.region  = psp_pkg::REG_INTERIOR;
    end
    return r;
  endfunction

  // record the expected projection of every accepted input beat
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      pending_q.push_back(project(in_if.start_x, in_if.start_y, in_if.end_x, in_if.end_y,
                                  in_if.point_x, in_if.point_y));
  end

  always @(posedge clk) begin
    projection_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_q.size() == 0) begin
        $error("result beat with nothing pending");
        fail_count++;
      end else begin
        exp_r = pending_q.pop_front();
        if (out_if.closest_x !== exp_r.cx) begin
          $error("closest_x exp %0h got %0h", exp_r.cx, out_if.closest_x);
          fail_count++;
        end
        if (out_if.closest_y !== exp_r.cy) begin
          $error("closest_y exp %0h got %0h", exp_r.cy, out_if.closest_y);
          fail_count++;
        end
        if (out_if.squared_distance !== exp_r.sq_dist) begin
          $error("squared_distance exp %0d got %0d", exp_r.sq_dist, out_if.squared_distance);
          fail_count++;
        end
        if (out_if.region !== exp_r.region) begin
          $error("region exp %0d got %0d", exp_r.region, out_if.region);
          fail_count++;
        end
      end
    end
  end

  // receiver: random stalls, or a counted long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_if.ready <= 1'b0;
      hold_cycles  <= hold_cycles - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_beat(logic [15:0] sx, logic [15:0] sy, logic [15:0] ex,
                           logic [15:0] ey, logic [15:0] px, logic [15:0] py);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid   <= 1'b1;
    in_if.start_x <= sx;
    in_if.start_y <= sy;
    in_if.end_x   <= ex;
    in_if.end_y   <= ey;
    in_if.point_x <= px;
    in_if.point_y <= py;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_q.size() != 0);
  endtask

  function automatic logic [15:0] near(logic [15:0] base, int unsigned span);
    return base + 16'($urandom_range(2 * span)) - 16'(span);
  endfunction

  // mostly short segments with the point nearby so all regions show up
  task automatic send_random(int n);
    logic [15:0] sx, sy, ex, ey, px, py;
    int unsigned span;
    repeat (n) begin
      case ($urandom_range(9))
        0, 1: begin
          sx = $urandom; sy = $urandom; ex = $urandom;
          ey = $urandom; px = $urandom; py = $urandom;
        end
        2: begin
          sx = $urandom; sy = $urandom; ex = sx; ey = sy;
          px = near(sx, $urandom_range(300));
          py = near(sy, $urandom_range(300));
        end
        default: begin
          span = ($urandom_range(3) == 0) ? 16000 : $urandom_range(1, 400);
          sx = $urandom; sy = $urandom;
          ex = near(sx, span); ey = near(sy, span);
          px = near(sx, 2 * span); py = near(sy, 2 * span);
        end
      endcase
      send_beat(sx, sy, ex, ey, px, py);
    end
  endtask

  task automatic test_directed();
    send_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);  // degenerate
    send_beat(16'h1234, 16'hfedc, 16'h1234, 16'hfedc, 16'h7fff, 16'h8000);  // degenerate, far
    send_beat(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);  // full span
    send_beat(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);  // point = end
    send_beat(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff);
    send_beat(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
    send_beat(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);  // e = 0
    send_beat(16'h0000, 16'h0000, 16'h0010, 16'h0000, 16'hfff0, 16'h0005);  // before start
    send_beat(16'h0000, 16'h0000, 16'h0010, 16'h0000, 16'h0020, 16'hfffb);  // past end
    send_beat(16'h0000, 16'h0000, 16'h0010, 16'h0000, 16'h0010, 16'h0033);  // e = f
    send_beat(16'h0000, 16'h0000, 16'h0010, 16'h0000, 16'h0007, 16'h0003);  // interior
    send_beat(16'h0000, 16'h0000, 16'hfff3, 16'hffe9, 16'hfffa, 16'hfff5);  // negative d
    send_beat(16'h0005, 16'hfffd, 16'h0008, 16'hfff9, 16'h0006, 16'hfffc);
    send_beat(16'h8000, 16'h0000, 16'h7fff, 16'h0001, 16'h0000, 16'h7fff);  // interior, long
    send_beat(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8001, 16'h8000);  // just past start
    send_beat(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7ffe, 16'h7fff);  // just short of end
    send_beat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
    send_beat(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
  endtask

  task automatic test_streaming();
    send_idle_pct = 0;  stall_pct = 0;  send_random(150);
    send_idle_pct = 68; stall_pct = 0;  send_random(150);
    send_idle_pct = 0;  stall_pct = 68; send_random(150);
    send_idle_pct = 14; stall_pct = 14; send_random(150);
  endtask

  // receiver holds off long enough that the pipe fills and in ready drops
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    @(posedge clk);
    hold_cycles <= 200;
    send_random(120);
    wait_drained();
    send_idle_pct = 30; stall_pct = 30;
    send_random(100);
    wait_drained();
    send_idle_pct = 0;  stall_pct = 0;
    send_random(80);
  endtask

  initial begin
    fail_count    = 0;
    cycle_count   = 0;
    hold_cycles   = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    @(posedge rst_n);
    @(posedge clk);
    test_directed();
    test_streaming();
    test_backpressure();
    wait_drained();
    repeat (Latency + 10) @(posedge clk);
    if (fail_count == 0 && pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
